>>> rtl/core/tnv_pkg.sv
// Shared types, constants and the multiply sequence for the triangle
// normal / volume accumulator. No dependencies.
`default_nettype none

package tnv_pkg;

    localparam int COORD_W    = 32;
    localparam int COORD_FRAC = 16;
    localparam int NFRAC      = 16;
    localparam int NORM_W     = NFRAC + 2;
    localparam int MAG_W      = NFRAC + 1;
    localparam int VOL_W      = 63;
    localparam int VOL_FRAC   = 32;

    localparam int EDGE_W = COORD_W + 1;
    localparam int OPD_W  = 35;
    localparam int PROD_W = 2 * OPD_W;
    localparam int ACC_W  = 140;
    localparam int CRS_W  = 67;
    localparam int Q_W    = 65;
    localparam int LO_W   = 34;
    localparam int SQ_W   = 136;
    localparam int RW     = 172;

    // volume: |T| >> (3*16 - 32) then / 6 == |T| >> 17, then / 3
    localparam int VSH    = 3 * COORD_FRAC - VOL_FRAC + 1;
    localparam int DIG_W  = 8;
    localparam int NDIG   = 11;
    localparam int U_W    = DIG_W * NDIG;
    localparam int RECIP3 = 683;
    localparam int RCP_SH = 11;

    localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

    localparam int NOPS  = 27;
    localparam int OP_W  = $clog2(NOPS);

    localparam logic [1:0] IX = 2'd0;
    localparam logic [1:0] IY = 2'd1;
    localparam logic [1:0] IZ = 2'd2;

    typedef enum logic [3:0] {
        OPD_E1, OPD_E2, OPD_P1, OPD_P2, OPD_P3, OPD_CLO, OPD_CHI, OPD_QLO, OPD_QHI
    } t_opnd;

    typedef enum logic [1:0] {SH_0, SH_34, SH_35, SH_68} t_shift;

    typedef enum logic [1:0] {DST_NONE, DST_C, DST_Q, DST_SQ} t_dest;

    typedef struct packed {
        t_opnd      a_kind;
        logic [1:0] a_idx;
        t_opnd      b_kind;
        logic [1:0] b_idx;
        t_shift     shift;
        logic       sub;
        logic       clr;
        t_dest      dest;
        logic [1:0] d_idx;
    } t_uop;

    typedef struct packed {
        logic   mul_en;
        logic   acc_en;
        logic   clr;
        logic   sub;
        t_shift shift;
    } t_mac_ctl;

    function automatic t_uop mk(t_opnd ak, logic [1:0] ai, t_opnd bk, logic [1:0] bi,
                                t_shift sh, logic sb, logic cl, t_dest d, logic [1:0] di);
        t_uop u;
        u.a_kind = ak;
        u.a_idx  = ai;
        u.b_kind = bk;
        u.b_idx  = bi;
        u.shift  = sh;
        u.sub    = sb;
        u.clr    = cl;
        u.dest   = d;
        u.d_idx  = di;
        return u;
    endfunction

    // edge cross product, vertex cross product, squares of c, triple product
    function automatic t_uop uop_at(logic [OP_W-1:0] idx);
        t_uop u;
        case (idx)
            5'd0:  u = mk(OPD_E1, IY, OPD_E2, IZ, SH_0, 1'b0, 1'b1, DST_NONE, IX);
            5'd1:  u = mk(OPD_E1, IZ, OPD_E2, IY, SH_0, 1'b1, 1'b0, DST_C, IX);
            5'd2:  u = mk(OPD_E1, IZ, OPD_E2, IX, SH_0, 1'b0, 1'b1, DST_NONE, IY);
            5'd3:  u = mk(OPD_E1, IX, OPD_E2, IZ, SH_0, 1'b1, 1'b0, DST_C, IY);
            5'd4:  u = mk(OPD_E1, IX, OPD_E2, IY, SH_0, 1'b0, 1'b1, DST_NONE, IZ);
            5'd5:  u = mk(OPD_E1, IY, OPD_E2, IX, SH_0, 1'b1, 1'b0, DST_C, IZ);
            5'd6:  u = mk(OPD_P2, IY, OPD_P3, IZ, SH_0, 1'b0, 1'b1, DST_NONE, IX);
            5'd7:  u = mk(OPD_P2, IZ, OPD_P3, IY, SH_0, 1'b1, 1'b0, DST_Q, IX);
            5'd8:  u = mk(OPD_P2, IZ, OPD_P3, IX, SH_0, 1'b0, 1'b1, DST_NONE, IY);
            5'd9:  u = mk(OPD_P2, IX, OPD_P3, IZ, SH_0, 1'b1, 1'b0, DST_Q, IY);
            5'd10: u = mk(OPD_P2, IX, OPD_P3, IY, SH_0, 1'b0, 1'b1, DST_NONE, IZ);
            5'd11: u = mk(OPD_P2, IY, OPD_P3, IX, SH_0, 1'b1, 1'b0, DST_Q, IZ);
            5'd12: u = mk(OPD_CLO, IX, OPD_CLO, IX, SH_0, 1'b0, 1'b1, DST_NONE, IX);
            5'd13: u = mk(OPD_CLO, IX, OPD_CHI, IX, SH_35, 1'b0, 1'b0, DST_NONE, IX);
            5'd14: u = mk(OPD_CHI, IX, OPD_CHI, IX, SH_68, 1'b0, 1'b0, DST_SQ, IX);
            5'd15: u = mk(OPD_CLO, IY, OPD_CLO, IY, SH_0, 1'b0, 1'b1, DST_NONE, IY);
            5'd16: u = mk(OPD_CLO, IY, OPD_CHI, IY, SH_35, 1'b0, 1'b0, DST_NONE, IY);
            5'd17: u = mk(OPD_CHI, IY, OPD_CHI, IY, SH_68, 1'b0, 1'b0, DST_SQ, IY);
            5'd18: u = mk(OPD_CLO, IZ, OPD_CLO, IZ, SH_0, 1'b0, 1'b1, DST_NONE, IZ);
            5'd19: u = mk(OPD_CLO, IZ, OPD_CHI, IZ, SH_35, 1'b0, 1'b0, DST_NONE, IZ);
            5'd20: u = mk(OPD_CHI, IZ, OPD_CHI, IZ, SH_68, 1'b0, 1'b0, DST_SQ, IZ);
            5'd21: u = mk(OPD_P1, IX, OPD_QLO, IX, SH_0, 1'b0, 1'b1, DST_NONE, IX);
            5'd22: u = mk(OPD_P1, IX, OPD_QHI, IX, SH_34, 1'b0, 1'b0, DST_NONE, IX);
            5'd23: u = mk(OPD_P1, IY, OPD_QLO, IY, SH_0, 1'b0, 1'b0, DST_NONE, IY);
            5'd24: u = mk(OPD_P1, IY, OPD_QHI, IY, SH_34, 1'b0, 1'b0, DST_NONE, IY);
            5'd25: u = mk(OPD_P1, IZ, OPD_QLO, IZ, SH_0, 1'b0, 1'b0, DST_NONE, IZ);
            5'd26: u = mk(OPD_P1, IZ, OPD_QHI, IZ, SH_34, 1'b0, 1'b0, DST_NONE, IZ);
            default: u = mk(OPD_E1, IX, OPD_E2, IX, SH_0, 1'b0, 1'b1, DST_NONE, IX);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/tnv_tri_if.sv
// Triangle input channel: valid/ready plus three vertices and mesh_end.
// Depends on tnv_pkg.
`default_nettype none

interface tnv_tri_if;
    import tnv_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic signed [COORD_W-1:0] third_x;
    logic signed [COORD_W-1:0] third_y;
    logic signed [COORD_W-1:0] third_z;
    logic                      mesh_end;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z, mesh_end,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z, mesh_end,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/tnv_res_if.sv
// Result channel: valid/ready plus normal, running volume and flags.
// Depends on tnv_pkg.
`default_nettype none

interface tnv_res_if;
    import tnv_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic [VOL_W-1:0]         volume_sum;
    logic                     degenerate;
    logic                     mesh_done;

    modport source (
        output valid, normal_x, normal_y, normal_z, volume_sum, degenerate, mesh_done,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, volume_sum, degenerate, mesh_done,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/tnv_mac.sv
// Shared 35x35 signed multiplier with registered product and a wide
// shift-accumulate stage. Depends on tnv_pkg.
`default_nettype none

module tnv_mac (
    input  wire                           i_clk,
    input  tnv_pkg::t_mac_ctl             i_ctl,
    input  wire signed [tnv_pkg::OPD_W-1:0] i_opa,
    input  wire signed [tnv_pkg::OPD_W-1:0] i_opb,
    output logic signed [tnv_pkg::ACC_W-1:0] o_acc,
    output logic signed [tnv_pkg::ACC_W-1:0] o_acc_next
);
    import tnv_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  ext;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  n_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_opa * i_opb;
        end
        if (i_ctl.acc_en) begin
            r_acc <= n_acc;
        end
    end

    always_comb begin
        ext = ACC_W'(r_prod);
        case (i_ctl.shift)
            SH_0:    term = ext;
            SH_34:   term = ext <<< 34;
            SH_35:   term = ext <<< 35;
            SH_68:   term = ext <<< 68;
            default: term = ext;
        endcase
        base  = i_ctl.clr ? '0 : r_acc;
        n_acc = i_ctl.sub ? (base - term) : (base + term);
    end

    assign o_acc      = r_acc;
    assign o_acc_next = n_acc;

endmodule

`default_nettype wire

>>> rtl/core/triangle_normal_volume_accumulator_core.sv
// Top level of the triangle normal / mesh volume accumulator.
// Depends on tnv_pkg, tnv_tri_if, tnv_res_if and tnv_mac.
//
// Usage:
//   i_tri carries one triangle word: three Q16.16 vertices and mesh_end.
//   o_res returns one word per triangle: the Q1.16 unit normal of
//   (p2-p1) x (p3-p1), the running mesh volume (32 fraction bits,
//   saturating), a degenerate flag and mesh_done (copy of mesh_end).
//   After a word with mesh_end set, the running volume restarts at zero.
//
//   From accept to result valid, one triangle runs through: 27 multiplies
//   on the shared multiplier (product, then accumulate), a sum step, a
//   bit-at-a-time normal magnitude search for each of the 3 components,
//   a byte-at-a-time divide-by-three on the volume increment and the load
//   of the output register. The input is ready again once that load is
//   done, so a new triangle is taken only after the last one is through.
//   A result that waits in the output register does not block the input,
//   but the next result holds in its final state until o_res is free.
//   Reset (i_rst_n low, synchronous) clears the sequencer, the output
//   valid and the running volume.
`default_nettype none

module triangle_normal_volume_accumulator_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tnv_tri_if.sink    i_tri,
    tnv_res_if.source  o_res
);
    import tnv_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MAC   = 7'b0000010,
        ST_SUM   = 7'b0000100,
        ST_NINIT = 7'b0001000,
        ST_NSTEP = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    logic [OP_W-1:0] r_op;
    logic            r_phase;
    logic [1:0]      r_comp;
    logic [4:0]      r_bit;
    logic [3:0]      r_dcnt;

    logic signed [COORD_W-1:0] r_p1 [3];
    logic signed [COORD_W-1:0] r_p2 [3];
    logic signed [COORD_W-1:0] r_p3 [3];
    logic signed [EDGE_W-1:0]  r_e1 [3];
    logic signed [EDGE_W-1:0]  r_e2 [3];
    logic signed [CRS_W-1:0]   r_c  [3];
    logic                      r_cneg [3];
    logic signed [Q_W-1:0]     r_q  [3];
    logic [SQ_W-1:0]           r_sq [3];
    logic [SQ_W-1:0]           r_s;
    logic                      r_end;

    logic [RW-1:0]    r_a;
    logic [RW-1:0]    r_bs;
    logic [RW-1:0]    r_sh2;
    logic [MAG_W-1:0] r_mag;
    logic [NORM_W-1:0] r_nrm [3];

    logic [U_W-1:0] r_u;
    logic [U_W-1:0] r_quo;
    logic [1:0]     r_rem;

    logic [VOL_W-1:0] r_vol;
    logic             r_oval;
    logic [NORM_W-1:0] r_o_nx, r_o_ny, r_o_nz;
    logic [VOL_W-1:0]  r_o_vol;
    logic              r_o_deg, r_o_done;

    t_uop     uop;
    t_mac_ctl mac_ctl;
    logic signed [OPD_W-1:0] opa, opb;
    logic signed [ACC_W-1:0] acc, acc_next;
    logic signed [CRS_W-1:0] csel;
    logic [CRS_W-1:0]        cmag;
    logic signed [Q_W-1:0]   qsel;
    logic [ACC_W-1:0]        tabs;

    logic            in_acc;
    logic            degen;
    logic [RW-1:0]   rr;
    logic [RW-1:0]   trial;
    logic            take;
    logic [MAG_W-1:0] mag_new;
    logic [MAG_W-1:0] mag_fin;
    logic [NORM_W-1:0] nrm_ext;

    logic [9:0]       dv;
    logic [19:0]      dprod;
    logic [DIG_W-1:0] qd;
    logic [9:0]       dsub;

    logic [VOL_W-1:0] incr;
    logic [VOL_W:0]   vsum;
    logic [VOL_W-1:0] vnew;
    logic             out_free;

    assign in_acc      = i_tri.valid && i_tri.ready;
    assign i_tri.ready = (r_state == ST_IDLE);
    assign out_free    = !r_oval || o_res.ready;

    // ---------------- multiply sequencer ----------------
    assign uop  = uop_at(r_op);
    assign csel = r_c[uop.a_idx];
    assign cmag = csel[CRS_W-1] ? CRS_W'(-csel) : csel;
    assign qsel = r_q[uop.a_idx];

    function automatic logic signed [OPD_W-1:0] pick(t_opnd k, logic [1:0] ix,
                                                     logic [CRS_W-1:0] cm,
                                                     logic signed [Q_W-1:0] qv);
        logic signed [OPD_W-1:0] v;
        case (k)
            OPD_E1:  v = OPD_W'(r_e1[ix]);
            OPD_E2:  v = OPD_W'(r_e2[ix]);
            OPD_P1:  v = OPD_W'(r_p1[ix]);
            OPD_P2:  v = OPD_W'(r_p2[ix]);
            OPD_P3:  v = OPD_W'(r_p3[ix]);
            OPD_CLO: v = $signed({1'b0, cm[LO_W-1:0]});
            OPD_CHI: v = $signed({2'b00, cm[CRS_W-1:LO_W]});
            OPD_QLO: v = $signed({1'b0, qv[LO_W-1:0]});
            OPD_QHI: v = OPD_W'($signed(qv[Q_W-1:LO_W]));
            default: v = '0;
        endcase
        return v;
    endfunction

    assign opa = pick(uop.a_kind, uop.a_idx, cmag, qsel);
    assign opb = pick(uop.b_kind, uop.b_idx, cmag, qsel);

    always_comb begin
        mac_ctl.mul_en = (r_state == ST_MAC) && !r_phase;
        mac_ctl.acc_en = (r_state == ST_MAC) && r_phase;
        mac_ctl.clr    = uop.clr;
        mac_ctl.sub    = uop.sub;
        mac_ctl.shift  = uop.shift;
    end

    tnv_mac u_mac (
        .i_clk      (i_clk),
        .i_ctl      (mac_ctl),
        .i_opa      (opa),
        .i_opb      (opb),
        .o_acc      (acc),
        .o_acc_next (acc_next)
    );

    assign tabs = acc[ACC_W-1] ? ACC_W'(-acc) : acc;

    // ---------------- normal magnitude search ----------------
    // A = mag^2*S, bs = mag*S << (b+1), sh2 = S << 2b; trial = cand^2 * S
    assign degen   = (r_s == '0);
    assign rr      = RW'({r_sq[r_comp], {(2 * NFRAC){1'b0}}});
    assign trial   = r_a + r_bs + r_sh2;
    assign take    = (trial <= rr);
    assign mag_new = take ? (r_mag | (MAG_W'(1) << r_bit)) : r_mag;
    assign mag_fin = degen ? '0 : mag_new;
    assign nrm_ext = r_cneg[r_comp] ? (~{1'b0, mag_fin} + 1'b1) : {1'b0, mag_fin};

    // ---------------- divide by three, one byte a step ----------------
    assign dv    = {r_rem, r_u[U_W-1 -: DIG_W]};
    assign dprod = 20'(dv * 10'(RECIP3));
    assign qd    = dprod[RCP_SH +: DIG_W];
    assign dsub  = dv - (10'(qd) * 10'd3);

    // ---------------- volume update ----------------
    assign incr = (|r_quo[U_W-1:VOL_W]) ? VOL_MAX : r_quo[VOL_W-1:0];
    assign vsum = {1'b0, r_vol} + {1'b0, incr};
    assign vnew = vsum[VOL_W] ? VOL_MAX : vsum[VOL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= '0;
            r_phase <= 1'b0;
            r_comp  <= '0;
            r_bit   <= '0;
            r_dcnt  <= '0;
            r_vol   <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (o_res.ready && !((r_state == ST_DONE) && out_free)) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_op    <= '0;
                        r_phase <= 1'b0;
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        if (r_op == OP_W'(NOPS - 1)) begin
                            r_state <= ST_SUM;
                        end else begin
                            r_op <= r_op + 1'b1;
                        end
                    end
                end
                ST_SUM: begin
                    r_comp  <= '0;
                    r_state <= ST_NINIT;
                end
                ST_NINIT: begin
                    r_bit   <= 5'(NFRAC);
                    r_state <= ST_NSTEP;
                end
                ST_NSTEP: begin
                    if (r_bit == '0) begin
                        if (r_comp == IZ) begin
                            r_dcnt  <= '0;
                            r_state <= ST_DIV;
                        end else begin
                            r_comp  <= r_comp + 1'b1;
                            r_state <= ST_NINIT;
                        end
                    end else begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
                ST_DIV: begin
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 4'(NDIG - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_oval  <= 1'b1;
                        r_vol   <= r_end ? '0 : vnew;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p1[0] <= i_tri.first_x;
            r_p1[1] <= i_tri.first_y;
            r_p1[2] <= i_tri.first_z;
            r_p2[0] <= i_tri.second_x;
            r_p2[1] <= i_tri.second_y;
            r_p2[2] <= i_tri.second_z;
            r_p3[0] <= i_tri.third_x;
            r_p3[1] <= i_tri.third_y;
            r_p3[2] <= i_tri.third_z;
            r_e1[0] <= EDGE_W'(i_tri.second_x) - EDGE_W'(i_tri.first_x);
            r_e1[1] <= EDGE_W'(i_tri.second_y) - EDGE_W'(i_tri.first_y);
            r_e1[2] <= EDGE_W'(i_tri.second_z) - EDGE_W'(i_tri.first_z);
            r_e2[0] <= EDGE_W'(i_tri.third_x) - EDGE_W'(i_tri.first_x);
            r_e2[1] <= EDGE_W'(i_tri.third_y) - EDGE_W'(i_tri.first_y);
            r_e2[2] <= EDGE_W'(i_tri.third_z) - EDGE_W'(i_tri.first_z);
            r_end   <= i_tri.mesh_end;
        end
        if ((r_state == ST_MAC) && r_phase) begin
            case (uop.dest)
                DST_C: begin
                    r_c[uop.d_idx]    <= acc_next[CRS_W-1:0];
                    r_cneg[uop.d_idx] <= acc_next[CRS_W-1];
                end
                DST_Q:    r_q[uop.d_idx]  <= acc_next[Q_W-1:0];
                DST_SQ:   r_sq[uop.d_idx] <= acc_next[SQ_W-1:0];
                default: ;
            endcase
        end
        if (r_state == ST_SUM) begin
            r_s   <= r_sq[0] + r_sq[1] + r_sq[2];
            r_u   <= tabs[VSH +: U_W];
            r_rem <= '0;
        end
        if (r_state == ST_NINIT) begin
            r_a   <= '0;
            r_bs  <= '0;
            r_sh2 <= RW'({r_s, {(2 * NFRAC){1'b0}}});
            r_mag <= '0;
        end
        if (r_state == ST_NSTEP) begin
            if (take) begin
                r_a <= trial;
            end
            r_bs  <= (r_bs >> 1) + (take ? r_sh2 : '0);
            r_sh2 <= r_sh2 >> 2;
            r_mag <= mag_new;
            if (r_bit == '0) begin
                r_nrm[r_comp] <= nrm_ext;
            end
        end
        if (r_state == ST_DIV) begin
            r_quo <= {r_quo[U_W-DIG_W-1:0], qd};
            r_u   <= r_u << DIG_W;
            r_rem <= dsub[1:0];
        end
        if ((r_state == ST_DONE) && out_free) begin
            r_o_nx   <= r_nrm[0];
            r_o_ny   <= r_nrm[1];
            r_o_nz   <= r_nrm[2];
            r_o_vol  <= vnew;
            r_o_deg  <= degen;
            r_o_done <= r_end;
        end
    end

    assign o_res.valid      = r_oval;
    assign o_res.normal_x   = r_o_nx;
    assign o_res.normal_y   = r_o_ny;
    assign o_res.normal_z   = r_o_nz;
    assign o_res.volume_sum = r_o_vol;
    assign o_res.degenerate = r_o_deg;
    assign o_res.mesh_done  = r_o_done;

endmodule

`default_nettype wire

>>> tb/triangle_normal_volume_accumulator_core_tb.sv
// Self-checking bench for triangle_normal_volume_accumulator_core: normals and
// running mesh volume checked word by word against an exact-width predictor.
// Depends on tnv_pkg, tnv_tri_if, tnv_res_if and the core RTL.
`default_nettype none

module triangle_normal_volume_accumulator_core_tb;
    import tnv_pkg::*;

    localparam int NUM_RANDOM  = 2000;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 300;

    typedef logic signed [127:0] wide_t;
    typedef wide_t vec3_t [3];

    typedef struct {
        logic signed [COORD_W-1:0] crd [9];
        logic                      mesh_end;
    } tri_word_t;

    typedef struct {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic [VOL_W-1:0]         vol;
        logic                     degen;
        logic                     done;
    } res_word_t;

    typedef struct {
        tri_word_t word;
        bit        typed;
        res_word_t want;
    } stim_row_t;

    localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] ONE  = 32'sh0001_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tnv_tri_if tri_ch ();
    tnv_res_if res_ch ();

    triangle_normal_volume_accumulator_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (tri_ch),
        .o_res   (res_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    res_word_t   pending_results [$];
    stim_row_t   directed [$];
    logic [63:0] mesh_volume;
    int          n_errors, n_sent, n_checked, n_degen, n_meshes, n_saturated;
    int          cycles;
    bit          no_stall;

    task automatic report(input string what);
        n_errors++;
        $display("MISMATCH @%0d: %s", cycles, what);
    endtask

    function automatic void cross3(input vec3_t a, input vec3_t b, output vec3_t o);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // Exact normal and volume step; updates the running mesh volume.
    function automatic res_word_t predict_triangle(input tri_word_t t);
        res_word_t   r;
        vec3_t       p1, p2, p3, e1, e2, c, q;
        wide_t       trip, abs_trip;
        logic [255:0] sum_sq, rhs, cand, mag, cm;
        logic [127:0] incr;
        logic [63:0]  inc64;
        logic signed [NORM_W-1:0] nrm [3];
        for (int i = 0; i < 3; i++) begin
            p1[i] = t.crd[i];
            p2[i] = t.crd[3+i];
            p3[i] = t.crd[6+i];
            e1[i] = p2[i] - p1[i];
            e2[i] = p3[i] - p1[i];
        end
        cross3(e1, e2, c);
        sum_sq = '0;
        for (int i = 0; i < 3; i++) begin
            cm = (c[i] < 0) ? 256'(-c[i]) : 256'(c[i]);
            sum_sq += cm * cm;
        end
        r.degen = (sum_sq == 0);
        for (int i = 0; i < 3; i++) begin
            mag = '0;
            if (!r.degen) begin
                cm  = (c[i] < 0) ? 256'(-c[i]) : 256'(c[i]);
                rhs = (cm * cm) << (2 * NFRAC);
                for (int b = NFRAC; b >= 0; b--) begin
                    cand = mag | (256'd1 << b);
                    if (cand * cand * sum_sq <= rhs) mag = cand;
                end
            end
            nrm[i] = (c[i] < 0) ? -NORM_W'(mag) : NORM_W'(mag);
        end
        r.nx = nrm[0];
        r.ny = nrm[1];
        r.nz = nrm[2];
        cross3(p2, p3, q);
        trip = p1[0] * q[0] + p1[1] * q[1] + p1[2] * q[2];
        abs_trip = (trip < 0) ? -trip : trip;
        incr  = (128'(abs_trip) >> (3 * COORD_FRAC - VOL_FRAC)) / 6;
        inc64 = (incr > 128'(VOL_MAX)) ? 64'(VOL_MAX) : incr[63:0];
        if (inc64 > 64'(VOL_MAX) - mesh_volume) mesh_volume = 64'(VOL_MAX);
        else mesh_volume = mesh_volume + inc64;
        r.vol  = mesh_volume[VOL_W-1:0];
        r.done = t.mesh_end;
        if (t.mesh_end) mesh_volume = '0;
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(input int mode);
        int r;
        r = $urandom_range(0, 9);
        case (mode)
            0: return $urandom;
            1: return COORD_W'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            default: begin
                case (r % 5)
                    0: return CMAX;
                    1: return CMIN;
                    2: return '0;
                    3: return -1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    function automatic tri_word_t random_triangle();
        tri_word_t t;
        int mode, shape;
        mode  = ($urandom_range(0, 9) < 6) ? 1 : ($urandom_range(0, 3) == 0 ? 2 : 0);
        shape = $urandom_range(0, 19);
        for (int i = 0; i < 9; i++) t.crd[i] = pick_coord(mode);
        // occasional collapsed triangles: repeated vertex or scaled edge
        if (shape == 0) begin
            for (int i = 0; i < 3; i++) t.crd[6+i] = t.crd[i];
        end else if (shape == 1) begin
            for (int i = 0; i < 3; i++) t.crd[3+i] = t.crd[i];
        end else if (shape == 2) begin
            for (int i = 0; i < 3; i++)
                t.crd[6+i] = t.crd[i] + 2 * (t.crd[3+i] - t.crd[i]);
        end
        t.mesh_end = ($urandom_range(0, 7) == 0);
        return t;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    function automatic tri_word_t mk_word(input logic signed [COORD_W-1:0] ax, ay, az,
                                          bx, by, bz, cx, cy, cz, input logic m_end);
        tri_word_t t;
        t.crd = '{ax, ay, az, bx, by, bz, cx, cy, cz};
        t.mesh_end = m_end;
        return t;
    endfunction

    task automatic add_row(input tri_word_t t, input bit typed,
                           input int nx, ny, nz, input logic [VOL_W-1:0] vol,
                           input logic degen);
        stim_row_t row;
        row.word       = t;
        row.typed      = typed;
        row.want.nx    = NORM_W'(nx);
        row.want.ny    = NORM_W'(ny);
        row.want.nz    = NORM_W'(nz);
        row.want.vol   = vol;
        row.want.degen = degen;
        row.want.done  = t.mesh_end;
        directed = {directed, row};
    endtask

    task automatic send_word(input tri_word_t t, input stim_row_t row);
        res_word_t r;
        res_word_t wanted;
        tri_ch.valid    <= 1'b1;
        tri_ch.first_x  <= t.crd[0];
        tri_ch.first_y  <= t.crd[1];
        tri_ch.first_z  <= t.crd[2];
        tri_ch.second_x <= t.crd[3];
        tri_ch.second_y <= t.crd[4];
        tri_ch.second_z <= t.crd[5];
        tri_ch.third_x  <= t.crd[6];
        tri_ch.third_y  <= t.crd[7];
        tri_ch.third_z  <= t.crd[8];
        tri_ch.mesh_end <= t.mesh_end;
        do @(posedge i_clk); while (!tri_ch.ready);
        r = predict_triangle(t);
        wanted = row.typed ? row.want : r;
        pending_results = {pending_results, wanted};
        n_sent++;
        if (r.degen) n_degen++;
        if (t.mesh_end) n_meshes++;
        if (r.vol == VOL_MAX) n_saturated++;
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            tri_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // stimulus
    initial begin
        stim_row_t none;
        tri_word_t t;
        none = '{default: '0};
        mesh_volume = '0;
        tri_ch.valid = 1'b0;
        tri_ch.first_x = '0;  tri_ch.first_y = '0;  tri_ch.first_z = '0;
        tri_ch.second_x = '0; tri_ch.second_y = '0; tri_ch.second_z = '0;
        tri_ch.third_x = '0;  tri_ch.third_y = '0;  tri_ch.third_z = '0;
        tri_ch.mesh_end = 1'b0;
        res_ch.ready = 1'b0;

        add_row(mk_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1, 0, 0, 0, '0, 1'b1);
        add_row(mk_word(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 1'b1), 1, 0, 0, 65536, '0, 1'b0);
        add_row(mk_word(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 1'b1), 1,
                37837, 37837, 37837, 63'd715827882, 1'b0);
        add_row(mk_word(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b1), 1,
                0, 0, 0, '0, 1'b1);
        add_row(mk_word(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b1), 1,
                0, 0, 0, '0, 1'b1);
        add_row(mk_word(0, 0, 0, 0, ONE, 0, ONE, 0, 0, 1'b0), 1, 0, 0, -65536, '0, 1'b0);
        add_row(mk_word(CMAX, 0, 0, 0, CMAX, 0, 0, 0, CMIN, 1'b0), 0, 0, 0, 0, '0, 1'b0);
        add_row(mk_word(CMIN, 0, 0, 0, CMIN, 0, 0, 0, CMIN, 1'b0), 0, 0, 0, 0, '0, 1'b0);
        add_row(mk_word(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 1'b1), 1,
                37837, 37837, 37837, VOL_MAX, 1'b0);
        add_row(mk_word(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, 1'b0),
                0, 0, 0, 0, '0, 1'b0);
        add_row(mk_word(CMAX, CMIN, 0, -1, CMAX, 1, CMIN, -1, CMAX, 1'b1), 0, 0, 0, 0, '0,
                1'b0);
        add_row(mk_word(-1, -1, -1, 1, 1, 1, -1, 1, -1, 1'b0), 0, 0, 0, 0, '0, 1'b0);
        add_row(mk_word(1, 0, 0, 0, 1, 0, 0, 0, 1, 1'b1), 0, 0, 0, 0, '0, 1'b0);
        // collinear: third vertex on the line through the first two
        add_row(mk_word(ONE, ONE, ONE, 2 * ONE, 3 * ONE, 4 * ONE, 3 * ONE, 5 * ONE, 7 * ONE,
                        1'b1), 1, 0, 0, 0, '0, 1'b1);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_word(directed[k].word, directed[k]);
            idle_gap(gap_len());
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM / 2) begin
                // hold off until the output side has fully drained
                tri_ch.valid <= 1'b0;
                wait (pending_results.size() == 0);
                @(posedge i_clk);
            end
            no_stall = (n >= 600 && n < 800);
            t = random_triangle();
            send_word(t, none);
            if (!no_stall) idle_gap(gap_len());
        end
        tri_ch.valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Covered %0d triangles (%0d degenerate), %0d mesh ends, %0d saturated sums",
                 n_sent, n_degen, n_meshes, n_saturated);
        $display("%0d result words checked, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0 && pending_results.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    // result checking and output backpressure
    int stall_left;
    always @(posedge i_clk) begin
        res_word_t w;
        cycles++;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                report("result word with nothing expected");
            end else begin
                w = pending_results.pop_front();
                n_checked++;
                if (res_ch.normal_x !== w.nx)
                    report($sformatf("normal_x %0d want %0d", res_ch.normal_x, w.nx));
                if (res_ch.normal_y !== w.ny)
                    report($sformatf("normal_y %0d want %0d", res_ch.normal_y, w.ny));
                if (res_ch.normal_z !== w.nz)
                    report($sformatf("normal_z %0d want %0d", res_ch.normal_z, w.nz));
                if (res_ch.volume_sum !== w.vol)
                    report($sformatf("volume_sum %h want %h", res_ch.volume_sum, w.vol));
                if (res_ch.degenerate !== w.degen)
                    report($sformatf("degenerate %b want %b", res_ch.degenerate, w.degen));
                if (res_ch.mesh_done !== w.done)
                    report($sformatf("mesh_done %b want %b", res_ch.mesh_done, w.done));
            end
        end
        if (no_stall) begin
            stall_left = 0;
            res_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end else begin
            stall_left = gap_len();
            res_ch.ready <= (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

`default_nettype wire
